// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, ignored while reset is high
`define VWMI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vwmi check failed");

// clocked check that also holds across reset
`define VWMI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vwmi check failed");

`endif

// ===== rtl/vwmi_pkg.sv =====
package vwmi_pkg;

  localparam int AXIS_VERTS_DEF = 32;

  localparam int COORD_W   = 5;
  localparam int VIDX_W    = 15;
  localparam int TRI_W     = 19;
  localparam int CFG_IDX_W = 2;
  localparam int CORNER_W  = 4;
  localparam int CORNERS   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

  localparam logic OP_CELL    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [COORD_W-1:0]  GRID_RESET   = 5'd31;
  localparam logic [TRI_W-1:0]    TRI_PER_WALL = 19'd4;
  localparam logic [CORNER_W-1:0] LAST_CORNER  = CORNER_W'(CORNERS - 1);

  typedef enum logic [1:0] {
    WALL_XY = 2'd0,
    WALL_XZ = 2'd1,
    WALL_YZ = 2'd2
  } wall_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } grid_t;

  // one vertex reference on its way to the map lookup unit
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [TRI_W-1:0]   tri_total;
    logic               last;
  } lookup_req_t;

  // corner offset of a wall: bit0 dx, bit1 dy, bit2 dz
  function automatic logic [2:0] corner_off(wall_t wall, logic [CORNER_W-1:0] corner);
    logic [1:0] p;
    logic [2:0] off;
    case (corner)
      4'd0:    p = 2'd0;
      4'd1:    p = 2'd1;
      4'd2:    p = 2'd2;
      4'd3:    p = 2'd3;
      4'd4:    p = 2'd1;
      4'd5:    p = 2'd2;
      4'd6:    p = 2'd2;
      4'd7:    p = 2'd1;
      4'd8:    p = 2'd0;
      4'd9:    p = 2'd2;
      4'd10:   p = 2'd1;
      4'd11:   p = 2'd3;
      default: p = 2'd0;
    endcase
    case (wall)
      WALL_XY: off = {1'b0, p[1], p[0]};
      WALL_XZ: off = {p[1], 1'b0, p[0]};
      WALL_YZ: off = {p[0], p[1], 1'b0};
      default: off = 3'b000;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/vwmi_cell_if.sv =====
interface vwmi_cell_if;
  import vwmi_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COORD_W-1:0] cell_z;
  logic               wall_xy;
  logic               wall_xz;
  logic               wall_yz;

  modport source (
    output valid, op, cell_x, cell_y, cell_z, wall_xy, wall_xz, wall_yz,
    input  ready
  );
  modport sink (
    input  valid, op, cell_x, cell_y, cell_z, wall_xy, wall_xz, wall_yz,
    output ready
  );
endinterface

// ===== rtl/vwmi_ref_if.sv =====
interface vwmi_ref_if;
  import vwmi_pkg::*;

  logic               valid;
  logic               ready;
  logic [VIDX_W-1:0]  vertex_index;
  logic               is_new;
  logic [COORD_W-1:0] vert_x;
  logic [COORD_W-1:0] vert_y;
  logic [COORD_W-1:0] vert_z;
  logic [TRI_W-1:0]   triangle_total;
  logic               run_end;

  modport source (
    output valid, vertex_index, is_new, vert_x, vert_y, vert_z, triangle_total, run_end,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, is_new, vert_x, vert_y, vert_z, triangle_total, run_end,
    output ready
  );
endinterface

// ===== rtl/vwmi_cfg_if.sv =====
interface vwmi_cfg_if;
  import vwmi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/vwmi_ram.sv =====
module vwmi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vwmi_seq.sv =====
module vwmi_seq #(
  parameter int AXIS_VERTS = vwmi_pkg::AXIS_VERTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vwmi_pkg::grid_t                     grid,
  vwmi_cell_if.sink                           voxel,
  input  logic                                lookup_idle,
  output vwmi_pkg::lookup_req_t               req,
  output logic [$clog2(AXIS_VERTS**3)-1:0]    req_addr,
  input  logic                                req_ready,
  output logic                                clearing,
  output logic [$clog2(AXIS_VERTS**3)-1:0]    clr_addr
);
  import vwmi_pkg::*;

  localparam int MAP_DEPTH = AXIS_VERTS**3;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam logic [ADDR_W-1:0]  AV_A     = ADDR_W'(AXIS_VERTS);
  localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(MAP_DEPTH - 1);
  localparam logic [COORD_W-1:0] CELL_MAX = COORD_W'(AXIS_VERTS - 2);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } seq_state_t;

  seq_state_t          state;
  logic [COORD_W-1:0]  cx, cy, cz;
  logic [2:0]          walls;
  logic [CORNER_W-1:0] corner;
  logic [TRI_W-1:0]    tri_count;

  wall_t               wall_sel;
  logic [2:0]          wall_bit;
  logic                last_wall;
  logic [2:0]          off;
  logic [COORD_W-1:0]  vx, vy, vz;
  logic                fire;
  logic                accept;
  logic                in_range;

  always_comb begin
    if (walls[0]) begin
      wall_sel = WALL_XY;
      wall_bit = 3'b001;
    end else if (walls[1]) begin
      wall_sel = WALL_XZ;
      wall_bit = 3'b010;
    end else begin
      wall_sel = WALL_YZ;
      wall_bit = 3'b100;
    end
  end

  assign last_wall = (walls & ~wall_bit) == 3'b000;
  assign off       = corner_off(wall_sel, corner);
  assign vx        = cx + COORD_W'(off[0]);
  assign vy        = cy + COORD_W'(off[1]);
  assign vz        = cz + COORD_W'(off[2]);
  assign req_addr  = (ADDR_W'(vx) * AV_A + ADDR_W'(vy)) * AV_A + ADDR_W'(vz);

  always_comb begin
    req.valid     = state == ST_RUN;
    req.x         = vx;
    req.y         = vy;
    req.z         = vz;
    req.tri_total = (corner == '0) ? tri_count + TRI_PER_WALL : tri_count;
    req.last      = (corner == LAST_CORNER) && last_wall;
  end

  assign fire        = req.valid && req_ready;
  assign voxel.ready = (state == ST_IDLE) && lookup_idle;
  assign accept      = voxel.valid && voxel.ready;
  assign clearing    = state == ST_CLEAR;

  assign in_range = (voxel.cell_x < grid.x) && (voxel.cell_y < grid.y) &&
                    (voxel.cell_z < grid.z) && (voxel.cell_x <= CELL_MAX) &&
                    (voxel.cell_y <= CELL_MAX) && (voxel.cell_z <= CELL_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      tri_count <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (voxel.op == OP_RESTART) begin
              state     <= ST_CLEAR;
              clr_addr  <= '0;
              tri_count <= '0;
            end else if (in_range && (voxel.wall_xy || voxel.wall_xz || voxel.wall_yz)) begin
              state  <= ST_RUN;
              cx     <= voxel.cell_x;
              cy     <= voxel.cell_y;
              cz     <= voxel.cell_z;
              walls  <= {voxel.wall_yz, voxel.wall_xz, voxel.wall_xy};
              corner <= '0;
            end
          end
        end
        ST_RUN: begin
          if (fire) begin
            if (corner == '0) begin
              tri_count <= tri_count + TRI_PER_WALL;
            end
            if (corner == LAST_CORNER) begin
              corner <= '0;
              walls  <= walls & ~wall_bit;
              if (last_wall) begin
                state <= ST_IDLE;
              end
            end else begin
              corner <= corner + CORNER_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/vwmi_lookup.sv =====
module vwmi_lookup #(
  parameter int AXIS_VERTS = vwmi_pkg::AXIS_VERTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clearing,
  input  vwmi_pkg::lookup_req_t                req,
  input  logic [$clog2(AXIS_VERTS**3)-1:0]     req_addr,
  output logic                                 req_ready,
  output logic                                 idle,
  input  logic [$clog2(AXIS_VERTS**3+1)-1:0]   rdata,
  output logic                                 we,
  output logic [$clog2(AXIS_VERTS**3)-1:0]     waddr,
  output logic [$clog2(AXIS_VERTS**3+1)-1:0]   wdata,
  vwmi_ref_if.source                           vref
);
  import vwmi_pkg::*;

  localparam int ADDR_W = $clog2(AXIS_VERTS**3);
  localparam int NV_W   = $clog2(AXIS_VERTS**3 + 1);

  lookup_req_t       s1;
  logic [ADDR_W-1:0] s1_addr;
  logic [NV_W-1:0]   next_vertex;
  logic              byp_valid;
  logic [ADDR_W-1:0] byp_addr;
  logic [NV_W-1:0]   byp_data;

  logic              adv;
  logic [NV_W-1:0]   entry;
  logic              miss;
  logic [NV_W-1:0]   idx;

  assign adv       = s1.valid && (!vref.valid || vref.ready);
  assign req_ready = !s1.valid || adv;
  assign idle      = !s1.valid;

  // previous reference may have written this address on the read edge
  assign entry = (byp_valid && (byp_addr == s1_addr)) ? byp_data : rdata;
  assign miss  = entry == '0;
  assign idx   = miss ? next_vertex : entry - NV_W'(1);

  assign we    = adv && miss;
  assign waddr = s1_addr;
  assign wdata = next_vertex + NV_W'(1);

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      s1.valid    <= 1'b0;
      next_vertex <= '0;
      byp_valid   <= 1'b0;
    end else begin
      if (req_ready) begin
        s1      <= req;
        s1_addr <= req_addr;
      end
      if (adv) begin
        if (miss) begin
          next_vertex <= next_vertex + NV_W'(1);
        end
        byp_valid <= 1'b1;
        byp_addr  <= s1_addr;
        byp_data  <= miss ? next_vertex + NV_W'(1) : entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vref.valid <= 1'b0;
    end else if (adv) begin
      vref.valid <= 1'b1;
    end else if (vref.ready) begin
      vref.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vref.vertex_index   <= VIDX_W'(idx);
      vref.is_new         <= miss;
      vref.vert_x         <= s1.x;
      vref.vert_y         <= s1.y;
      vref.vert_z         <= s1.z;
      vref.triangle_total <= s1.tri_total;
      vref.run_end        <= s1.last;
    end
  end

endmodule

// ===== rtl/voxel_wall_mesh_indexer.sv =====
// A cell transaction is latched into the sequencer, each request is registered in the
// lookup stage and each result in the vertex reference register. Throughput: one reference
// per cycle while the output is not stalled (12 per set wall, up to 36 per cell) through
// the single map lookup/assign unit. Empty and rejected cells produce no references.
// Reset: clearing pass over all AXIS_VERTS**3 map entries (32768 at default); a restart
// transaction also starts it. No cell accepted meanwhile; config taken.
module voxel_wall_mesh_indexer #(
  parameter int AXIS_VERTS = vwmi_pkg::AXIS_VERTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  vwmi_cell_if.sink voxel,
  vwmi_ref_if.source vref,
  vwmi_cfg_if.sink  cfg
);
  import vwmi_pkg::*;

  localparam int MAP_DEPTH = AXIS_VERTS**3;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  // map entries hold index+1, zero means unassigned
  localparam int NV_W      = $clog2(MAP_DEPTH + 1);

  // grid size registers; the user must write them only while idle, the block does not enforce it
  grid_t grid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid.x <= GRID_RESET;
      grid.y <= GRID_RESET;
      grid.z <= GRID_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GRID_X: grid.x <= cfg.data;
        REG_GRID_Y: grid.y <= cfg.data;
        REG_GRID_Z: grid.z <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  lookup_req_t       req;
  logic [ADDR_W-1:0] req_addr;
  logic              req_ready;
  logic              lookup_idle;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic              lk_we;
  logic [ADDR_W-1:0] lk_waddr;
  logic [NV_W-1:0]   lk_wdata;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [NV_W-1:0]   ram_wdata;
  logic [NV_W-1:0]   ram_rdata;

  // Sequencer: latches the cell, walks walls and corners, runs the clear sweep.
  vwmi_seq #(
    .AXIS_VERTS (AXIS_VERTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .grid        (grid),
    .voxel       (voxel),
    .lookup_idle (lookup_idle),
    .req         (req),
    .req_addr    (req_addr),
    .req_ready   (req_ready),
    .clearing    (clearing),
    .clr_addr    (clr_addr)
  );

  // Shared unit: one map read-modify-write per cycle while the output is not stalled; result register.
  vwmi_lookup #(
    .AXIS_VERTS (AXIS_VERTS)
  ) u_lookup (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .req       (req),
    .req_addr  (req_addr),
    .req_ready (req_ready),
    .idle      (lookup_idle),
    .rdata     (ram_rdata),
    .we        (lk_we),
    .waddr     (lk_waddr),
    .wdata     (lk_wdata),
    .vref      (vref)
  );

  // The sweep owns the write port; the lookup stage is empty while it runs.
  assign ram_we    = clearing || lk_we;
  assign ram_waddr = clearing ? clr_addr : lk_waddr;
  assign ram_wdata = clearing ? '0 : lk_wdata;

  vwmi_ram #(
    .WIDTH (NV_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req.valid && req_ready),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/vwmi_checker.sv =====
`include "assert_macros.svh"

module vwmi_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         voxel_ready,
  input logic                         vref_valid,
  input logic                         vref_ready,
  input logic [vwmi_pkg::VIDX_W-1:0]  vref_vertex_index,
  input logic                         vref_is_new,
  input logic [vwmi_pkg::COORD_W-1:0] vref_vert_x,
  input logic [vwmi_pkg::COORD_W-1:0] vref_vert_y,
  input logic [vwmi_pkg::COORD_W-1:0] vref_vert_z,
  input logic [vwmi_pkg::TRI_W-1:0]   vref_triangle_total,
  input logic                         vref_run_end
);
  import vwmi_pkg::*;

  logic             ref_acc;
  logic             have_prev;
  logic [TRI_W-1:0] last_tri;
  logic             last_end;

  assign ref_acc = vref_valid && vref_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      last_end  <= 1'b1;
    end else if (ref_acc) begin
      have_prev <= 1'b1;
      last_tri  <= vref_triangle_total;
      last_end  <= vref_run_end;
    end
  end

  // stalled result holds
  `VWMI_ASSERT(a_ref_hold, clk, rst, (vref_valid && !vref_ready) |=> (vref_valid && $stable(vref_vertex_index) && $stable(vref_is_new) && $stable(vref_vert_x) && $stable(vref_vert_y) && $stable(vref_vert_z) && $stable(vref_triangle_total) && $stable(vref_run_end)))

  // no new cell while a run is still being delivered
  `VWMI_ASSERT(a_no_accept_mid_run, clk, rst, (vref_valid && !vref_run_end) |-> !voxel_ready)

  // within a run the triangle total holds or steps by one wall
  `VWMI_ASSERT(a_tri_step, clk, rst, (ref_acc && have_prev && !last_end) |-> ((vref_triangle_total == last_tri) || (vref_triangle_total == last_tri + TRI_PER_WALL)))

  // reset starts the map clearing pass
  `VWMI_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !voxel_ready)

endmodule

bind voxel_wall_mesh_indexer vwmi_checker u_vwmi_checker (
  .clk                 (clk),
  .rst                 (rst),
  .voxel_ready         (voxel.ready),
  .vref_valid          (vref.valid),
  .vref_ready          (vref.ready),
  .vref_vertex_index   (vref.vertex_index),
  .vref_is_new         (vref.is_new),
  .vref_vert_x         (vref.vert_x),
  .vref_vert_y         (vref.vert_y),
  .vref_vert_z         (vref.vert_z),
  .vref_triangle_total (vref.triangle_total),
  .vref_run_end        (vref.run_end)
);
